// File: hw/rtl/bptc_pkg.sv
package bptc_pkg;

    localparam int unsigned NUM_CELLS = 64;

    typedef enum logic [2:0] {
        REG_T1    = 3'd0,
        REG_T23   = 3'd1,
        REG_P1    = 3'd2,
        REG_P23   = 3'd3,
        REG_P45   = 3'd4,
        REG_P67   = 3'd5,
        REG_P89   = 3'd6
    } bptc_reg_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } bptc_coef_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] milli;
        logic        invalid;
        logic        neg;
    } bptc_side_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] den;
    } bptc_div_t;

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] milli;
        logic [31:0] press_q;
        logic [31:0] press_mh;
        logic        invalid;
    } bptc_res_t;

endpackage

// File: hw/rtl/baro_pressure_temp_compensation.sv
// Throughput: one reading pair per cycle while s_tready is high (it drops
// while the skid entry is full); the 64-bit division is a chain of
// 64 restoring cells, one quotient bit per cell, pipelined with the multipliers.
// A two-entry output buffer lets input transfers continue while a result waits.
// Reset (aresetn low, synchronous) clears all calibration registers to zero
// and empties the pipeline.
module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // raw_pressure, raw_temperature
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // fine_temperature, temperature_centi_c,
                                    // temperature_milli_c, pressure_pa_q24_8,
                                    // pressure_mhpa
    output logic         m_tuser    // pressure_invalid
);

    logic [15:0] t1_reg, p1_reg;
    logic [31:0] t23_reg, p23_reg, p45_reg, p67_reg, p89_reg;
    bptc_coef_t  coef;
    logic        wr_en;
    bptc_reg_t   waddr;

    logic        en;
    logic        cv [0:NUM_CELLS];
    bptc_div_t   cd [0:NUM_CELLS];
    bptc_side_t  cs [0:NUM_CELLS];
    logic        pipe_valid;
    bptc_res_t   pipe_res;
    logic        out_valid_reg, skid_valid_reg;
    bptc_res_t   out_reg, skid_reg;
    logic        take_out;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign waddr  = bptc_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg  <= '0;
            t23_reg <= '0;
            p1_reg  <= '0;
            p23_reg <= '0;
            p45_reg <= '0;
            p67_reg <= '0;
            p89_reg <= '0;
        end else if (wr_en) begin
            unique case (waddr)
                REG_T1:  t1_reg  <= pwdata[15:0];
                REG_T23: t23_reg <= pwdata;
                REG_P1:  p1_reg  <= pwdata[15:0];
                REG_P23: p23_reg <= pwdata;
                REG_P45: p45_reg <= pwdata;
                REG_P67: p67_reg <= pwdata;
                REG_P89: p89_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (waddr)
            REG_T1:  prdata = {16'd0, t1_reg};
            REG_T23: prdata = t23_reg;
            REG_P1:  prdata = {16'd0, p1_reg};
            REG_P23: prdata = p23_reg;
            REG_P45: prdata = p45_reg;
            REG_P67: prdata = p67_reg;
            REG_P89: prdata = p89_reg;
            default: prdata = 32'd0;
        endcase
    end

    always_comb begin
        coef.t1 = t1_reg;
        coef.t2 = t23_reg[15:0];
        coef.t3 = t23_reg[31:16];
        coef.p1 = p1_reg;
        coef.p2 = p23_reg[15:0];
        coef.p3 = p23_reg[31:16];
        coef.p4 = p45_reg[15:0];
        coef.p5 = p45_reg[31:16];
        coef.p6 = p67_reg[15:0];
        coef.p7 = p67_reg[31:16];
        coef.p8 = p89_reg[15:0];
        coef.p9 = p89_reg[31:16];
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    bptc_pre u_pre (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid && s_tready),
        .adc_p     (s_tdata[19:0]),
        .adc_t     (s_tdata[39:20]),
        .coef      (coef),
        .out_valid (cv[0]),
        .out_data  (cd[0]),
        .out_side  (cs[0])
    );

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        bptc_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[g]),
            .in_data   (cd[g]),
            .in_side   (cs[g]),
            .out_valid (cv[g+1]),
            .out_data  (cd[g+1]),
            .out_side  (cs[g+1])
        );
    end

    bptc_post u_post (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (cv[NUM_CELLS]),
        .in_quot   (cd[NUM_CELLS].nq),
        .in_side   (cs[NUM_CELLS]),
        .coef      (coef),
        .out_valid (pipe_valid),
        .out_res   (pipe_res)
    );

    assign take_out = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take_out) begin
                out_reg        <= skid_reg;
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid) begin
            if (take_out) begin
                out_reg       <= pipe_res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= pipe_res;
                skid_valid_reg <= 1'b1;
            end
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.press_mh, out_reg.press_q, out_reg.milli,
                       out_reg.centi, out_reg.fine};
    assign m_tuser  = out_reg.invalid;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without an output entry");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready && !skid_valid_reg && pipe_valid) |=> skid_valid_reg)
        else $error("pipeline result lost while output stalled");

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid entry changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (out_reg.press_q == 32'd0 && out_reg.press_mh == 32'd0))
        else $error("pressure not cleared on zero divisor");
`endif

endmodule

// File: hw/rtl/bptc_div_cell.sv
module bptc_div_cell
    import bptc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  bptc_div_t  in_data,
    input  bptc_side_t in_side,
    output logic       out_valid,
    output bptc_div_t  out_data,
    output bptc_side_t out_side
);

    logic       valid_reg;
    bptc_div_t  data_reg;
    bptc_side_t side_reg;
    logic [64:0] trial;
    logic [64:0] diff;
    bptc_div_t  data_next;

    always_comb begin
        trial = {in_data.rem, in_data.nq[63]};
        diff  = trial - {1'b0, in_data.den};
        data_next.den = in_data.den;
        if (!diff[64]) begin
            data_next.rem = diff[63:0];
            data_next.nq  = {in_data.nq[62:0], 1'b1};
        end else begin
            data_next.rem = trial[63:0];
            data_next.nq  = {in_data.nq[62:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/bptc_pre.sv
module bptc_pre
    import bptc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  logic [19:0] adc_p,
    input  logic [19:0] adc_t,
    input  bptc_coef_t coef,
    output logic       out_valid,
    output bptc_div_t  out_data,
    output bptc_side_t out_side
);

    logic [10:0] vld_reg;
    logic [19:0] adcp_reg [0:7];
    logic [31:0] s1_m1_reg, s1_dd_reg, s2_a_reg, s2_m2_reg;
    logic [31:0] fine_reg [3:10];
    logic [31:0] centi_reg [4:10];
    logic [31:0] milli_reg [5:10];
    logic signed [32:0] s4_ap_reg;
    logic [63:0] s5_aa_reg;
    logic signed [48:0] s5_ap5_reg, s5_ap2_reg;
    logic [63:0] s6_b1_reg, s6_aa3_reg, s6_bp_reg, s6_ap2_reg;
    logic [63:0] s7_b_reg, s7_av_reg, s8_pp_reg, s8_b_reg;
    logic [63:0] s9_den_reg, s9_diff_reg, s10_num_reg, s10_den_reg;
    logic        s10_inv_reg;
    bptc_div_t  out_reg;
    bptc_side_t side_reg;

    logic signed [18:0] x;
    logic signed [34:0] px;
    logic signed [16:0] d;
    logic signed [33:0] pd;
    logic signed [31:0] ddsh;
    logic signed [47:0] pm2;
    logic [31:0] f5;
    logic signed [65:0] paa;
    logic signed [48:0] pap5, pap2;
    logic signed [79:0] pb1, pa3;
    logic [63:0] bpart, ap2s, sum47;
    logic signed [80:0] ppp;
    logic [20:0] pr21;
    logic signed [75:0] pn;

    always_comb begin
        x    = $signed({2'b00, adc_t[19:3]}) - $signed({2'b00, coef.t1, 1'b0});
        px   = x * $signed(coef.t2);
        d    = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, coef.t1});
        pd   = d * d;
        ddsh = $signed(s1_dd_reg) >>> 12;
        pm2  = ddsh * $signed(coef.t3);
        f5   = fine_reg[3] * 32'd5 + 32'd128;
        paa  = s4_ap_reg * s4_ap_reg;
        pap5 = s4_ap_reg * $signed(coef.p5);
        pap2 = s4_ap_reg * $signed(coef.p2);
        pb1  = $signed(s5_aa_reg) * $signed(coef.p6);
        pa3  = $signed(s5_aa_reg) * $signed(coef.p3);
        bpart = ({{15{s5_ap5_reg[48]}}, s5_ap5_reg} << 17)
              + ({{48{coef.p4[15]}}, coef.p4} << 35);
        ap2s  = {{15{s5_ap2_reg[48]}}, s5_ap2_reg} << 12;
        sum47 = s7_av_reg + 64'h0000_8000_0000_0000;
        ppp   = $signed(sum47) * $signed({1'b0, coef.p1});
        pr21  = 21'd1048576 - {1'b0, adcp_reg[7]};
        pn    = $signed(s9_diff_reg) * 13'sd3125;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[9:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            adcp_reg[0] <= adc_p;
            for (int i = 1; i < 8; i++) begin
                adcp_reg[i] <= adcp_reg[i-1];
            end
            s1_m1_reg <= px[31:0];
            s1_dd_reg <= pd[31:0];
            s2_a_reg  <= 32'($signed(s1_m1_reg) >>> 11);
            s2_m2_reg <= pm2[31:0];
            fine_reg[3] <= s2_a_reg + 32'($signed(s2_m2_reg) >>> 14);
            for (int i = 4; i < 11; i++) begin
                fine_reg[i] <= fine_reg[i-1];
            end
            centi_reg[4] <= 32'($signed(f5) >>> 8);
            for (int i = 5; i < 11; i++) begin
                centi_reg[i] <= centi_reg[i-1];
            end
            s4_ap_reg <= $signed({fine_reg[3][31], fine_reg[3]}) - 33'sd128000;
            milli_reg[5] <= centi_reg[4] * 32'd10;
            for (int i = 6; i < 11; i++) begin
                milli_reg[i] <= milli_reg[i-1];
            end
            s5_aa_reg  <= paa[63:0];
            s5_ap5_reg <= pap5;
            s5_ap2_reg <= pap2;
            s6_b1_reg  <= pb1[63:0];
            s6_aa3_reg <= pa3[63:0];
            s6_bp_reg  <= bpart;
            s6_ap2_reg <= ap2s;
            s7_b_reg   <= s6_b1_reg + s6_bp_reg;
            s7_av_reg  <= 64'($signed(s6_aa3_reg) >>> 8) + s6_ap2_reg;
            s8_pp_reg  <= ppp[63:0];
            s8_b_reg   <= s7_b_reg;
            s9_den_reg  <= 64'($signed(s8_pp_reg) >>> 33);
            s9_diff_reg <= ({43'd0, pr21} << 31) - s8_b_reg;
            s10_num_reg <= pn[63:0];
            s10_den_reg <= s9_den_reg;
            s10_inv_reg <= (s9_den_reg == 64'd0);
            out_reg.rem <= '0;
            out_reg.nq  <= s10_num_reg[63] ? -s10_num_reg : s10_num_reg;
            out_reg.den <= s10_den_reg[63] ? -s10_den_reg : s10_den_reg;
            side_reg.fine    <= fine_reg[10];
            side_reg.centi   <= centi_reg[10];
            side_reg.milli   <= milli_reg[10];
            side_reg.invalid <= s10_inv_reg;
            side_reg.neg     <= s10_num_reg[63] ^ s10_den_reg[63];
        end
    end

    assign out_valid = vld_reg[10];
    assign out_data  = out_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/bptc_post.sv
module bptc_post
    import bptc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  logic [63:0] in_quot,
    input  bptc_side_t in_side,
    input  bptc_coef_t coef,
    output logic       out_valid,
    output bptc_res_t  out_res
);

    logic [5:0]  vld_reg;
    bptc_side_t  side_reg [0:4];
    logic [63:0] q_reg [0:3];
    logic [51:0] d1_ll_reg;
    logic signed [51:0] d1_lh_reg;
    logic signed [49:0] d1_hh_reg;
    logic [63:0] d1_bq_reg, d2_sq_reg, d2_b_reg, d3_b_reg, d3_a_reg;
    logic [31:0] d4_pq_reg;
    bptc_res_t   res_reg;

    logic [25:0] lo;
    logic signed [24:0] hi;
    logic signed [79:0] pbq, pam;
    logic [63:0] sq;
    logic [63:0] pr;
    logic [35:0] pmh;

    always_comb begin
        lo  = q_reg[0][38:13];
        hi  = $signed(q_reg[0][63:39]);
        pbq = $signed(q_reg[0]) * $signed(coef.p8);
        sq  = {12'd0, d1_ll_reg}
            + ({{12{d1_lh_reg[51]}}, d1_lh_reg} << 27)
            + ({{14{d1_hh_reg[49]}}, d1_hh_reg} << 52);
        pam = $signed(d2_sq_reg) * $signed(coef.p9);
        pr  = 64'($signed(q_reg[3] + d3_a_reg + d3_b_reg) >>> 8)
            + ({{48{coef.p7[15]}}, coef.p7} << 4);
        pmh = {4'd0, d4_pq_reg} * 36'd10;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 1; i < 5; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            q_reg[0] <= in_side.neg ? -in_quot : in_quot;
            for (int i = 1; i < 4; i++) begin
                q_reg[i] <= q_reg[i-1];
            end
            d1_ll_reg <= {26'd0, lo} * {26'd0, lo};
            d1_lh_reg <= $signed({1'b0, lo}) * hi;
            d1_hh_reg <= hi * hi;
            d1_bq_reg <= pbq[63:0];
            d2_sq_reg <= sq;
            d2_b_reg  <= 64'($signed(d1_bq_reg) >>> 19);
            d3_a_reg  <= 64'($signed(pam[63:0]) >>> 25);
            d3_b_reg  <= d2_b_reg;
            d4_pq_reg <= side_reg[3].invalid ? 32'd0 : pr[31:0];
            res_reg.fine     <= side_reg[4].fine;
            res_reg.centi    <= side_reg[4].centi;
            res_reg.milli    <= side_reg[4].milli;
            res_reg.press_q  <= d4_pq_reg;
            res_reg.press_mh <= {4'd0, pmh[35:8]};
            res_reg.invalid  <= side_reg[4].invalid;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_res   = res_reg;

endmodule

// File: bench/tb_baro_pressure_temp_compensation.sv
module tb_baro_pressure_temp_compensation
    import bptc_pkg::*;
();

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;     // raw_pressure, raw_temperature
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [159:0] m_tdata;          // fine_temperature, temperature_centi_c,
                                    // temperature_milli_c, pressure_pa_q24_8,
                                    // pressure_mhpa
    logic         m_tuser;          // pressure_invalid

    typedef struct packed {
        logic [31:0] fine;
        logic [31:0] centi;
        logic [31:0] milli;
        logic [31:0] press_q;
        logic [31:0] press_mh;
        logic        invalid;
    } comp_res_t;

    comp_res_t   pending_results[$];
    logic [31:0] cal_regs[7];
    int          errors = 0;
    longint      cycle_count = 0;
    bit          hold_off = 1'b0;
    bit          sink_random = 1'b1;

    localparam longint CYCLE_LIMIT = 2000000;

    baro_pressure_temp_compensation dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic longint s16(logic [15:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint w32(longint x);
        return longint'(signed'(x[31:0]));
    endfunction

    function automatic comp_res_t compensate(logic [19:0] adc_p, logic [19:0] adc_t);
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint a, b, d, fine, centi, milli, q, pr;
        comp_res_t r;
        t1 = longint'(cal_regs[REG_T1][15:0]);
        t2 = s16(cal_regs[REG_T23][15:0]);
        t3 = s16(cal_regs[REG_T23][31:16]);
        p1 = longint'(cal_regs[REG_P1][15:0]);
        p2 = s16(cal_regs[REG_P23][15:0]);
        p3 = s16(cal_regs[REG_P23][31:16]);
        p4 = s16(cal_regs[REG_P45][15:0]);
        p5 = s16(cal_regs[REG_P45][31:16]);
        p6 = s16(cal_regs[REG_P67][15:0]);
        p7 = s16(cal_regs[REG_P67][31:16]);
        p8 = s16(cal_regs[REG_P89][15:0]);
        p9 = s16(cal_regs[REG_P89][31:16]);
        a = w32(((longint'(adc_t) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
        d = (longint'(adc_t) >>> 4) - t1;
        b = w32((w32(d * d) >>> 12) * t3) >>> 14;
        fine = w32(a + b);
        centi = w32(fine * 5 + 128) >>> 8;
        milli = w32(centi * 10);
        r = '0;
        r.fine = fine[31:0];
        r.centi = centi[31:0];
        r.milli = milli[31:0];
        a = fine - 128000;
        b = a * a * p6;
        b = b + ((a * p5) <<< 17);
        b = b + (p4 <<< 35);
        a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
        if (a == 0) begin
            r.invalid = 1'b1;
        end else begin
            pr = 1048576 - longint'(adc_p);
            pr = ((pr <<< 31) - b) * 3125;
            if (pr == 64'sh8000000000000000 && a == -1)
                q = pr;
            else
                q = pr / a;
            a = (p9 * (q >>> 13) * (q >>> 13)) >>> 25;
            b = (p8 * q) >>> 19;
            pr = ((q + a + b) >>> 8) + (p7 <<< 4);
            r.press_q = pr[31:0];
            r.press_mh = 32'((64'(pr[31:0]) * 10) >> 8);
        end
        return r;
    endfunction

    task automatic write_reg(bptc_reg_t idx, logic [31:0] val);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cal_regs[idx] = (idx == REG_T1 || idx == REG_P1) ? {16'h0, val[15:0]} : val;
    endtask

    task automatic load_coeffs(logic [31:0] v[7]);
        for (int i = 0; i < 7; i++)
            write_reg(bptc_reg_t'(i), v[i]);
    endtask

    task automatic send_reading(logic [19:0] p, logic [19:0] t, bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t, p};
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(compensate(p, t));
    endtask

    task automatic end_burst();
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        end_burst();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        comp_res_t got, exp_r;
        if (m_tvalid && m_tready) begin
            got.fine     = m_tdata[31:0];
            got.centi    = m_tdata[63:32];
            got.milli    = m_tdata[95:64];
            got.press_q  = m_tdata[127:96];
            got.press_mh = m_tdata[159:128];
            got.invalid  = m_tuser;
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (got.fine !== exp_r.fine) begin
                    $error("fine_temperature exp %h got %h", exp_r.fine, got.fine); errors++;
                end
                if (got.centi !== exp_r.centi) begin
                    $error("temperature_centi_c exp %h got %h", exp_r.centi, got.centi);
                    errors++;
                end
                if (got.milli !== exp_r.milli) begin
                    $error("temperature_milli_c exp %h got %h", exp_r.milli, got.milli);
                    errors++;
                end
                if (got.press_q !== exp_r.press_q) begin
                    $error("pressure_pa_q24_8 exp %h got %h", exp_r.press_q, got.press_q);
                    errors++;
                end
                if (got.press_mh !== exp_r.press_mh) begin
                    $error("pressure_mhpa exp %h got %h", exp_r.press_mh, got.press_mh);
                    errors++;
                end
                if (got.invalid !== exp_r.invalid) begin
                    $error("pressure_invalid exp %b got %b", exp_r.invalid, got.invalid);
                    errors++;
                end
            end
        end
    end

    // Receiver stall pattern; a long hold-off is counted here in cycles.
    initial begin
        int n;
        forever begin
            if (hold_off) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_off = 1'b0;
            end else if (sink_random && $urandom_range(0, 3) == 0) begin
                n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    function automatic logic [31:0] typical(int i);
        logic [31:0] v[7] = '{32'h00006E9F, 32'hFFCE6685, 32'h00008E28,
                              32'h0BD0D5F9, 32'hFFF9235E, 32'h3CE4FFF9, 32'h1770D6D0};
        return v[i];
    endfunction

    task automatic test_reset_coefficients();
        // All coefficients zero gives a zero divisor.
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        drain();
    endtask

    task automatic test_extreme_readings();
        logic [31:0] v[7];
        for (int i = 0; i < 7; i++) v[i] = typical(i);
        load_coeffs(v);
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        send_reading(20'h00000, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'h00000, 0);
        send_reading(20'h5A3C0, 20'h7E1B0, 0);
        send_reading(20'hAAAAA, 20'h55555, 0);
        drain();
    endtask

    task automatic test_extreme_coefficients();
        logic [31:0] v[7];
        for (int i = 0; i < 7; i++) v[i] = 32'hFFFFFFFF;
        load_coeffs(v);
        send_reading(20'h12345, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'h00000, 0);
        drain();
        for (int i = 0; i < 7; i++) v[i] = 32'h80007FFF;
        v[REG_T1] = 32'h0000FFFF;
        load_coeffs(v);
        send_reading(20'h00000, 20'hFFFFF, 0);
        send_reading(20'h80000, 20'h80000, 0);
        drain();
        for (int i = 0; i < 7; i++) v[i] = 32'h7FFF8000;
        load_coeffs(v);
        send_reading(20'h00001, 20'h00001, 0);
        send_reading(20'hFFFFF, 20'h7FFFF, 0);
        drain();
        // P1 of zero forces the invalid flag with nonzero other coefficients.
        for (int i = 0; i < 7; i++) v[i] = typical(i);
        v[REG_P1] = 32'h0;
        load_coeffs(v);
        send_reading(20'h65432, 20'h81234, 0);
        drain();
    endtask

    task automatic test_random_readings(int n);
        logic [31:0] v[7];
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < 7; i++)
                v[i] = (ph == 0) ? typical(i) : $urandom;
            if (ph == 3) v[REG_P1] = $urandom_range(0, 3);
            load_coeffs(v);
            for (int k = 0; k < n / 4; k++)
                send_reading(20'($urandom_range(0, 20'hFFFFF)),
                             20'($urandom_range(0, 20'hFFFFF)), 1);
            drain();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int k = 0; k < 150; k++)
            send_reading(20'($urandom_range(0, 20'hFFFFF)),
                         20'($urandom_range(0, 20'hFFFFF)), 0);
        drain();
        for (int k = 0; k < 100; k++)
            send_reading(20'($urandom_range(0, 20'hFFFFF)),
                         20'($urandom_range(0, 20'hFFFFF)), 0);
        drain();
    endtask

    initial begin
        for (int i = 0; i < 7; i++) cal_regs[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_coefficients();
        test_extreme_readings();
        test_extreme_coefficients();
        test_backpressure();
        test_random_readings(1600);
        repeat (100) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
